[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl files that check their own behavior
// no dependencies; every macro samples at the rising edge and is held off in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle
`define ASSERT_NOW(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property whose consequent is checked in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/gprc_pkg.sv]
// shared types and constants of the grid path residue counter
// no dependencies; imported by the interfaces and every module of the block but gprc_ram
package gprc_pkg;

  // count arithmetic
  localparam int COUNT_W = 30;
  localparam logic [COUNT_W-1:0] COUNT_MOD = 30'd1000000007;

  // field and register widths
  localparam int CELL_W  = 16;
  localparam int MOD_W   = 7;
  localparam int COLS_W  = 11;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  // job fields are sized for the largest allowed parameter values
  localparam int SHIFT_W = 8;
  localparam int COL_W   = 16;

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // register indexes of the apb port
  typedef enum logic {
    REG_MODULUS      = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } cfg_reg_t;

  // one classified cell, handed from the front to the back
  typedef struct packed {
    logic [SHIFT_W-1:0] shift;      // cell value mod k
    logic [COL_W-1:0]   col;        // column of the cell
    logic               first_row;  // no top neighbor
    logic               has_left;   // column is not zero
    logic               last;       // ends the grid, emits a result
  } cell_job_t;

endpackage

[rtl/core/gprc_in_if.sv]
// input channel of the grid path residue counter: one cell per transaction
// depends on gprc_pkg
interface gprc_in_if import gprc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_value;
  logic              last_cell;

  modport source (output valid, cell_value, last_cell, input ready);
  modport sink   (input valid, cell_value, last_cell, output ready);
endinterface

[rtl/core/gprc_out_if.sv]
// result channel of the grid path residue counter: one count per transaction
// depends on gprc_pkg
interface gprc_out_if import gprc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] path_count;

  modport source (output valid, path_count, input ready);
  modport sink   (input valid, path_count, output ready);
endinterface

[rtl/core/gprc_ram.sv]
// generic single write port, single read port ram with registered read data
// no dependencies
module gprc_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/core/gprc_queue.sv]
// short queue of classified cells between the front and the back
// depends on gprc_pkg
module gprc_queue import gprc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  cell_job_t push_data,
  output logic      pop_valid,
  input  logic      pop_ready,
  output cell_job_t pop_data
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cell_job_t       slot_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count_r != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

[rtl/core/gprc_front.sv]
// front end: accepts cells, reduces the value mod k one bit a cycle,
// tracks the raster position and pushes a classified job; depends on gprc_pkg
module gprc_front import gprc_pkg::*; #(
  parameter int MAX_K       = 64,
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               restart,
  input  logic [$clog2(MAX_K+1)-1:0]         eff_k,
  input  logic [$clog2(MAX_COLUMNS+1)-1:0]   eff_cols,
  gprc_in_if.sink                            in_ch,
  output logic                               job_valid,
  input  logic                               job_ready,
  output cell_job_t                          job
);

  localparam int KW  = $clog2(MAX_K + 1);
  localparam int CW  = $clog2(MAX_COLUMNS + 1);
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int BW  = $clog2(CELL_W);

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  front_state_t      state_r;
  logic [CELL_W-1:0] dividend_r;
  logic              last_r;
  logic [KW-1:0]     rem_r;
  logic [BW-1:0]     bit_cnt_r;
  logic [CIW-1:0]    col_r;
  logic              first_row_r;
  logic [KW:0]       rem_shift;
  logic [KW-1:0]     rem_nxt;
  logic [CW-1:0]     col_inc;

  // one restoring remainder step
  always_comb begin
    rem_shift = {rem_r, dividend_r[CELL_W-1]};
    if (rem_shift >= {1'b0, eff_k}) begin
      rem_nxt = KW'(rem_shift - {1'b0, eff_k});
    end else begin
      rem_nxt = KW'(rem_shift);
    end
  end

  assign col_inc     = CW'(col_r) + CW'(1);
  assign in_ch.ready = (state_r == F_IDLE);
  assign job_valid   = (state_r == F_PUSH);

  // classified job
  always_comb begin
    job.shift     = SHIFT_W'(rem_r);
    job.col       = COL_W'(col_r);
    job.first_row = first_row_r;
    job.has_left  = (col_r != '0);
    job.last      = last_r;
  end

  // sequencer and raster position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= F_IDLE;
      col_r       <= '0;
      first_row_r <= 1'b1;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_ch.valid) begin
            dividend_r <= in_ch.cell_value;
            last_r     <= in_ch.last_cell;
            rem_r      <= '0;
            bit_cnt_r  <= '0;
            state_r    <= F_DIV;
          end
        end
        F_DIV: begin
          rem_r      <= rem_nxt;
          dividend_r <= {dividend_r[CELL_W-2:0], 1'b0};
          bit_cnt_r  <= bit_cnt_r + BW'(1);
          if (bit_cnt_r == BW'(CELL_W - 1)) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (job_ready) begin
            state_r <= F_IDLE;
            if (last_r) begin
              col_r       <= '0;
              first_row_r <= 1'b1;
            end else if (col_inc >= eff_cols) begin
              col_r       <= '0;
              first_row_r <= 1'b0;
            end else begin
              col_r <= CIW'(col_inc);
            end
          end
        end
        default: begin
          state_r <= F_IDLE;
        end
      endcase
      // register write starts a new grid
      if (restart) begin
        col_r       <= '0;
        first_row_r <= 1'b1;
      end
    end
  end

endmodule

[rtl/core/gprc_back.sv]
// back end: sweeps the k residues of one cell through the line buffer,
// left buffer and rotation table; holds the result register
// depends on gprc_pkg, gprc_ram and gprc_out_if
module gprc_back import gprc_pkg::*; #(
  parameter int MAX_K       = 64,
  parameter int MAX_COLUMNS = 1024
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [$clog2(MAX_K+1)-1:0] eff_k,
  input  logic                       job_valid,
  output logic                       job_ready,
  input  cell_job_t                  job,
  gprc_out_if.source                 out_ch
);

  localparam int KW  = $clog2(MAX_K + 1);
  localparam int OW  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int CIW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_DEPTH  = 2 ** (CIW + OW);
  localparam int LEFT_DEPTH = 2 ** (OW + 1);
  localparam int OFS_DEPTH  = 2 ** CIW;

  typedef enum logic [2:0] {
    B_IDLE,
    B_OFS,
    B_SWEEP,
    B_DRAIN,
    B_DONE
  } back_state_t;

  back_state_t        state_r;
  cell_job_t          job_r;
  logic [KW-1:0]      idx_r;
  logic [KW-1:0]      rtop_r;
  logic               lb_r;
  logic               s2_valid_r;
  logic [KW-1:0]      s2_idx_r;
  logic [OW-1:0]      s2_phys_r;
  logic [COUNT_W-1:0] res_hold_r;
  logic               out_valid_r;
  logic [COUNT_W-1:0] out_count_r;

  logic [CIW-1:0]     col;
  logic [KW-1:0]      shift_k;
  logic [KW-1:0]      phys;
  logic [KW:0]        dst_sum;
  logic [KW-1:0]      dst;
  logic [KW:0]        rnew_sum;
  logic [KW-1:0]      rnew;
  logic [COUNT_W-1:0] top_val;
  logic [COUNT_W-1:0] left_val;
  logic [COUNT_W:0]   raw_sum;
  logic [COUNT_W-1:0] fresh;
  logic               seed;

  logic [COUNT_W-1:0] row_rdata;
  logic [COUNT_W-1:0] left_rdata;
  logic [OW-1:0]      ofs_rdata;

  assign col     = job_r.col[CIW-1:0];
  assign shift_k = KW'(job_r.shift[OW-1:0]);

  // physical slot of logical residue idx in the top vector
  always_comb begin
    if (idx_r >= rtop_r) begin
      phys = idx_r - rtop_r;
    end else begin
      phys = idx_r + eff_k - rtop_r;
    end
  end

  // rotated destination and the rotation of the new vector
  always_comb begin
    dst_sum  = {1'b0, s2_idx_r} + {1'b0, shift_k};
    dst      = (dst_sum >= {1'b0, eff_k}) ? KW'(dst_sum - {1'b0, eff_k}) : KW'(dst_sum);
    rnew_sum = {1'b0, rtop_r} + {1'b0, shift_k};
    rnew     = (rnew_sum >= {1'b0, eff_k}) ? KW'(rnew_sum - {1'b0, eff_k}) : KW'(rnew_sum);
  end

  // top plus left, seeded at the origin, reduced once
  always_comb begin
    top_val  = job_r.first_row ? '0 : row_rdata;
    left_val = job_r.has_left ? left_rdata : '0;
    seed     = job_r.first_row && !job_r.has_left && (s2_idx_r == '0);
    raw_sum  = {1'b0, top_val} + {1'b0, left_val} + {{COUNT_W{1'b0}}, seed};
    if (raw_sum >= {1'b0, COUNT_MOD}) begin
      fresh = COUNT_W'(raw_sum - {1'b0, COUNT_MOD});
    end else begin
      fresh = COUNT_W'(raw_sum);
    end
  end

  // line buffer, stored in place with a per-column rotation
  gprc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (ROW_DEPTH)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s2_valid_r),
    .wr_addr ({col, s2_phys_r}),
    .wr_data (fresh),
    .rd_addr ({col, OW'(phys)}),
    .rd_data (row_rdata)
  );

  // left neighbor vector, two banks swapped every cell
  gprc_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (LEFT_DEPTH)
  ) u_left_ram (
    .clk     (clk),
    .wr_en   (s2_valid_r),
    .wr_addr ({~lb_r, OW'(dst)}),
    .wr_data (fresh),
    .rd_addr ({lb_r, OW'(idx_r)}),
    .rd_data (left_rdata)
  );

  // rotation of each column's stored vector
  gprc_ram #(
    .WIDTH (OW),
    .DEPTH (OFS_DEPTH)
  ) u_ofs_ram (
    .clk     (clk),
    .wr_en   (state_r == B_DRAIN),
    .wr_addr (col),
    .wr_data (OW'(rnew)),
    .rd_addr (job.col[CIW-1:0]),
    .rd_data (ofs_rdata)
  );

  assign job_ready      = (state_r == B_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.path_count = out_count_r;

  // sequencer, sweep counter and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      s2_valid_r  <= 1'b0;
      lb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      s2_valid_r <= 1'b0;
      if (s2_valid_r && (dst == '0)) begin
        res_hold_r <= fresh;
      end
      unique case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            state_r <= B_OFS;
          end
        end
        B_OFS: begin
          rtop_r  <= job_r.first_row ? '0 : KW'(ofs_rdata);
          idx_r   <= '0;
          state_r <= B_SWEEP;
        end
        B_SWEEP: begin
          s2_valid_r <= 1'b1;
          s2_idx_r   <= idx_r;
          s2_phys_r  <= OW'(phys);
          idx_r      <= idx_r + KW'(1);
          if (idx_r == eff_k - KW'(1)) begin
            state_r <= B_DRAIN;
          end
        end
        B_DRAIN: begin
          lb_r    <= ~lb_r;
          state_r <= B_DONE;
        end
        B_DONE: begin
          if (!job_r.last) begin
            state_r <= B_IDLE;
          end else if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_count_r <= res_hold_r;
            state_r     <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/grid_path_residue_count.sv]
// grid path residue counter
// Cells arrive on in_ch in raster order, one per transaction (cell_value,
// last_cell). For each cell the block builds the per-residue path counts
// (mod 1e9+7) of right/down paths from the top-left cell. The transaction
// with last_cell set produces one out_ch transaction carrying the count of
// paths whose sum is divisible by k, and starts a new grid.
// Registers on the APB port: 0x0 modulus k, 0x4 column_count. A write
// restarts the grid; writes must be made only while the block is idle,
// which the block itself does not enforce. The front reduces the value
// mod k one bit per cycle, and the back sweeps the k residues of each cell
// through the line buffer ram one per cycle. A two-entry queue between
// them lets both run together, so the front can take a new cell while
// the back is still sweeping the last one.
// Reset: k = 1, one column, new grid; the rams need no clearing pass.
// A stalled out_ch holds its result while further cells are taken; a second
// result waits in the back until the first has left.
// depends on gprc_pkg, gprc_in_if, gprc_out_if, gprc_front, gprc_queue, gprc_back
module grid_path_residue_count import gprc_pkg::*; #(
  parameter int MAX_K       = 64,
  parameter int MAX_COLUMNS = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  gprc_in_if.sink           in_ch,
  gprc_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

`include "assert_macros.svh"

  localparam int KW = $clog2(MAX_K + 1);
  localparam int CW = $clog2(MAX_COLUMNS + 1);

  logic [MOD_W-1:0]  modulus_r;
  logic [COLS_W-1:0] column_count_r;
  logic              cfg_write;
  cfg_reg_t          reg_sel;
  logic [KW-1:0]     eff_k;
  logic [CW-1:0]     eff_cols;
  logic              job_push_valid;
  logic              job_push_ready;
  cell_job_t         job_push;
  logic              job_pop_valid;
  logic              job_pop_ready;
  cell_job_t         job_pop;

  // register file
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign reg_sel   = cfg_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r      <= MOD_W'(1);
      column_count_r <= COLS_W'(1);
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_MODULUS:      modulus_r      <= pwdata[MOD_W-1:0];
        REG_COLUMN_COUNT: column_count_r <= pwdata[COLS_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_MODULUS:      prdata = DATA_W'(modulus_r);
      REG_COLUMN_COUNT: prdata = DATA_W'(column_count_r);
    endcase
  end

  // clamp the registers to the supported ranges
  always_comb begin
    if (modulus_r == '0) begin
      eff_k = KW'(1);
    end else if (int'(modulus_r) > MAX_K) begin
      eff_k = KW'(MAX_K);
    end else begin
      eff_k = KW'(modulus_r);
    end
    if (column_count_r == '0) begin
      eff_cols = CW'(1);
    end else if (int'(column_count_r) > MAX_COLUMNS) begin
      eff_cols = CW'(MAX_COLUMNS);
    end else begin
      eff_cols = CW'(column_count_r);
    end
  end

  gprc_front #(
    .MAX_K       (MAX_K),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (cfg_write),
    .eff_k     (eff_k),
    .eff_cols  (eff_cols),
    .in_ch     (in_ch),
    .job_valid (job_push_valid),
    .job_ready (job_push_ready),
    .job       (job_push)
  );

  gprc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_push_valid),
    .push_ready (job_push_ready),
    .push_data  (job_push),
    .pop_valid  (job_pop_valid),
    .pop_ready  (job_pop_ready),
    .pop_data   (job_pop)
  );

  gprc_back #(
    .MAX_K       (MAX_K),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .eff_k     (eff_k),
    .job_valid (job_pop_valid),
    .job_ready (job_pop_ready),
    .job       (job_pop),
    .out_ch    (out_ch)
  );

  // checks
  `ASSERT_NOW(a_count_reduced, clk, rst_n, !out_ch.valid || (out_ch.path_count < COUNT_MOD), "result count not reduced")
  `ASSERT_NEXT(a_front_busy, clk, rst_n, in_ch.valid && in_ch.ready, !in_ch.ready, "front took a transaction while reducing")
  `ASSERT_NOW(a_job_col_range, clk, rst_n, !job_push_valid || (CW'(job_push.col) < eff_cols), "job column beyond row length")
  `ASSERT_NOW(a_job_shift_range, clk, rst_n, !job_push_valid || (KW'(job_push.shift) < eff_k), "job residue not below k")

endmodule
